FILE: rtl/owm_pkg.sv
// Shared types and constants for the 1-Wire bus master.
package owm_pkg;

    localparam int LEAD_IN_TICKS_DEF = 10;
    localparam int WAIT_BITS_DEF     = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_EARLY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_LATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOVER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SLOT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SLOT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVER  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_FREE      = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       line_level;
    } t_in;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       presence;
        logic       rejected;
    } t_out;

    typedef struct packed {
        logic [15:0] reset_low_ticks;
        logic [15:0] presence_early_ticks;
        logic [15:0] presence_late_ticks;
        logic [15:0] reset_recovery_ticks;
        logic [7:0]  short_slot_ticks;
        logic [7:0]  long_slot_ticks;
        logic [7:0]  read_recovery_ticks;
        logic [15:0] bus_free_timeout;
    } t_cfg;

endpackage

FILE: rtl/owm_cfg_regs.sv
// Configuration register file of the 1-Wire bus master.
module owm_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [owm_pkg::CFG_W-1:0]     i_cfg_data,
    output owm_pkg::t_cfg                 o_cfg
);
    import owm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks      <= 16'd480;
            r_cfg.presence_early_ticks <= 16'd30;
            r_cfg.presence_late_ticks  <= 16'd60;
            r_cfg.reset_recovery_ticks <= 16'd380;
            r_cfg.short_slot_ticks     <= 8'd5;
            r_cfg.long_slot_ticks      <= 8'd60;
            r_cfg.read_recovery_ticks  <= 8'd50;
            r_cfg.bus_free_timeout     <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESET_LOW:     r_cfg.reset_low_ticks      <= i_cfg_data;
                CFG_PRES_EARLY:    r_cfg.presence_early_ticks <= i_cfg_data;
                CFG_PRES_LATE:     r_cfg.presence_late_ticks  <= i_cfg_data;
                CFG_RESET_RECOVER: r_cfg.reset_recovery_ticks <= i_cfg_data;
                CFG_SHORT_SLOT:    r_cfg.short_slot_ticks     <= i_cfg_data[7:0];
                CFG_LONG_SLOT:     r_cfg.long_slot_ticks      <= i_cfg_data[7:0];
                CFG_READ_RECOVER:  r_cfg.read_recovery_ticks  <= i_cfg_data[7:0];
                CFG_BUS_FREE:      r_cfg.bus_free_timeout     <= i_cfg_data;
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/owm_core.sv
// Operation state and single-step update logic of the 1-Wire bus master.
module owm_core #(
    parameter int LEAD_IN_TICKS = owm_pkg::LEAD_IN_TICKS_DEF,
    parameter int WAIT_BITS     = owm_pkg::WAIT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  owm_pkg::t_in  i_item,
    input  owm_pkg::t_cfg i_cfg,
    output owm_pkg::t_out o_result
);
    import owm_pkg::*;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    localparam logic [2:0] PH_0 = 3'd0;
    localparam logic [2:0] PH_1 = 3'd1;
    localparam logic [2:0] PH_2 = 3'd2;
    localparam logic [2:0] PH_3 = 3'd3;
    localparam logic [2:0] PH_4 = 3'd4;

    localparam logic [31:0] WAIT_MASK = 32'((64'd1 << WAIT_BITS) - 64'd1);
    localparam logic [31:0] LEAD_IN   = 32'(LEAD_IN_TICKS);

    t_op                  r_op, n_op;
    logic [2:0]           r_phase, n_phase;
    logic [3:0]           r_bit_count, n_bit_count;
    logic [7:0]           r_shift, n_shift;
    logic [WAIT_BITS-1:0] r_wait, n_wait;
    logic                 r_present, n_present;
    logic                 r_drive, n_drive;
    logic [7:0]           r_rx, n_rx;

    logic                 done;
    logic                 rej;
    logic                 load_en;
    logic [31:0]          load_val;
    logic                 fire;
    logic [WAIT_BITS-1:0] wait_dec;
    logic                 tx_bit;

    assign fire     = (r_wait <= WAIT_BITS'(1));
    assign wait_dec = r_wait - WAIT_BITS'(1);
    assign tx_bit   = r_shift[0];

    always_comb begin
        n_op        = r_op;
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_wait      = r_wait;
        n_present   = r_present;
        n_drive     = r_drive;
        n_rx        = r_rx;
        done        = 1'b0;
        rej         = 1'b0;
        load_en     = 1'b0;
        load_val    = 32'd0;

        if (i_accept) begin
            if (i_item.kind == KIND_TICK) begin
                case (r_op)
                    OP_RESET: begin
                        if (r_phase == PH_0) begin
                            n_wait = wait_dec;
                            if (wait_dec == '0) begin
                                n_present = 1'b0;
                                n_op      = OP_IDLE;
                                n_phase   = PH_0;
                                n_drive   = 1'b0;
                                done      = 1'b1;
                            end else if (i_item.line_level) begin
                                n_drive  = 1'b1;
                                load_en  = 1'b1;
                                load_val = 32'(i_cfg.reset_low_ticks);
                                n_phase  = PH_1;
                            end
                        end else if (!fire) begin
                            n_wait = wait_dec;
                        end else begin
                            n_wait = '0;
                            case (r_phase)
                                PH_1: begin
                                    n_drive  = 1'b0;
                                    load_en  = 1'b1;
                                    load_val = 32'(i_cfg.presence_early_ticks);
                                    n_phase  = PH_2;
                                end
                                PH_2: begin
                                    n_present = !i_item.line_level;
                                    load_en   = 1'b1;
                                    load_val  = 32'(i_cfg.presence_late_ticks);
                                    n_phase   = PH_3;
                                end
                                PH_3: begin
                                    if (!r_present) begin
                                        n_present = !i_item.line_level;
                                    end
                                    load_en  = 1'b1;
                                    load_val = 32'(i_cfg.reset_recovery_ticks);
                                    n_phase  = PH_4;
                                end
                                default: begin
                                    n_op    = OP_IDLE;
                                    n_phase = PH_0;
                                    n_drive = 1'b0;
                                    done    = 1'b1;
                                end
                            endcase
                        end
                    end
                    OP_WRITE: begin
                        if (!fire) begin
                            n_wait = wait_dec;
                        end else begin
                            n_wait = '0;
                            if (r_phase == PH_1) begin
                                n_drive     = 1'b0;
                                load_en     = 1'b1;
                                load_val    = tx_bit ? 32'(i_cfg.long_slot_ticks)
                                                     : 32'(i_cfg.short_slot_ticks);
                                n_shift     = r_shift >> 1;
                                n_bit_count = r_bit_count + 4'd1;
                                n_phase     = PH_2;
                            end else if (r_phase == PH_2 && r_bit_count[3]) begin
                                n_op    = OP_IDLE;
                                n_phase = PH_0;
                                n_drive = 1'b0;
                                done    = 1'b1;
                            end else begin
                                n_drive  = 1'b1;
                                load_en  = 1'b1;
                                load_val = tx_bit ? 32'(i_cfg.short_slot_ticks)
                                                  : 32'(i_cfg.long_slot_ticks);
                                n_phase  = PH_1;
                            end
                        end
                    end
                    OP_READ: begin
                        if (!fire) begin
                            n_wait = wait_dec;
                        end else begin
                            n_wait = '0;
                            case (r_phase)
                                PH_1: begin
                                    n_drive  = 1'b0;
                                    load_en  = 1'b1;
                                    load_val = 32'(i_cfg.short_slot_ticks);
                                    n_phase  = PH_2;
                                end
                                PH_2: begin
                                    n_shift     = {i_item.line_level, r_shift[7:1]};
                                    n_bit_count = r_bit_count + 4'd1;
                                    load_en     = 1'b1;
                                    load_val    = 32'(i_cfg.read_recovery_ticks);
                                    n_phase     = PH_3;
                                end
                                default: begin
                                    if (r_phase == PH_3 && r_bit_count[3]) begin
                                        n_rx    = r_shift;
                                        n_op    = OP_IDLE;
                                        n_phase = PH_0;
                                        n_drive = 1'b0;
                                        done    = 1'b1;
                                    end else begin
                                        n_drive  = 1'b1;
                                        load_en  = 1'b1;
                                        load_val = 32'(i_cfg.short_slot_ticks);
                                        n_phase  = PH_1;
                                    end
                                end
                            endcase
                        end
                    end
                    default: begin
                        n_op = r_op;
                    end
                endcase
            end else if (r_op != OP_IDLE) begin
                rej = 1'b1;
            end else begin
                n_op        = t_op'(i_item.kind);
                n_drive     = 1'b0;
                n_bit_count = 4'd0;
                n_phase     = PH_0;
                load_en     = 1'b1;
                if (i_item.kind == KIND_RESET) begin
                    load_val = 32'(i_cfg.bus_free_timeout);
                end else begin
                    n_shift  = (i_item.kind == KIND_WRITE) ? i_item.tx_byte : 8'd0;
                    load_val = LEAD_IN;
                end
            end
        end

        if (load_en) begin
            n_wait = (load_val > WAIT_MASK) ? WAIT_BITS'(WAIT_MASK) : WAIT_BITS'(load_val);
        end
        if (n_op == OP_IDLE) begin
            n_wait = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= OP_IDLE;
            r_phase     <= PH_0;
            r_bit_count <= 4'd0;
            r_shift     <= 8'd0;
            r_wait      <= '0;
            r_present   <= 1'b0;
            r_drive     <= 1'b0;
            r_rx        <= 8'd0;
        end else begin
            r_op        <= n_op;
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_wait      <= n_wait;
            r_present   <= n_present;
            r_drive     <= n_drive;
            r_rx        <= n_rx;
        end
    end

    always_comb begin
        o_result.drive_low = n_drive;
        o_result.busy_res  = (n_op != OP_IDLE);
        o_result.done_res  = done;
        o_result.rx_byte   = n_rx;
        o_result.presence  = n_present;
        o_result.rejected  = rej;
    end

endmodule

FILE: rtl/onewire_bus_master.sv
// Top level of the 1-Wire bus master: handshakes, result register and submodules.
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one item per cycle; the input is ready whenever the result register
// is empty or its result is taken in the same cycle.
// Reset: synchronous, active low; clears the operation state and the valid flag of the
// result register, and loads the configuration registers with their default timings.
module onewire_bus_master #(
    parameter int LEAD_IN_TICKS = owm_pkg::LEAD_IN_TICKS_DEF,
    parameter int WAIT_BITS     = owm_pkg::WAIT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  owm_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output owm_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [owm_pkg::CFG_W-1:0]     i_cfg_data
);
    import owm_pkg::*;

    t_cfg  cfg;
    t_out  result;
    logic  accept;
    logic  r_out_valid;
    t_out  r_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    owm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    owm_core #(
        .LEAD_IN_TICKS (LEAD_IN_TICKS),
        .WAIT_BITS     (WAIT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
